@@ design/tmm_pkg.sv @@
// Shared types and constants of the tiny memory machine core.
package tmm_pkg;

    localparam logic [1:0] CMD_LOAD    = 2'd0;
    localparam logic [1:0] CMD_EXEC    = 2'd1;
    localparam logic [1:0] CMD_RESTART = 2'd2;

    localparam logic [2:0] ST_RUN     = 3'd0;
    localparam logic [2:0] ST_TERM    = 3'd1;
    localparam logic [2:0] ST_END     = 3'd2;
    localparam logic [2:0] ST_NEGADDR = 3'd3;
    localparam logic [2:0] ST_DIVZERO = 3'd4;

    localparam logic [3:0] OP_VALUE  = 4'd0;
    localparam logic [3:0] OP_READ   = 4'd1;
    localparam logic [3:0] OP_WRITE  = 4'd2;
    localparam logic [3:0] OP_ASSIGN = 4'd3;
    localparam logic [3:0] OP_MOVE   = 4'd4;
    localparam logic [3:0] OP_LOAD   = 4'd5;
    localparam logic [3:0] OP_STORE  = 4'd6;
    localparam logic [3:0] OP_ADD    = 4'd7;
    localparam logic [3:0] OP_SUB    = 4'd8;
    localparam logic [3:0] OP_MUL    = 4'd9;
    localparam logic [3:0] OP_MOD    = 4'd10;
    localparam logic [3:0] OP_EQ     = 4'd11;
    localparam logic [3:0] OP_LESS   = 4'd12;
    localparam logic [3:0] OP_JUMP   = 4'd13;
    localparam logic [3:0] OP_JUMPIF = 4'd14;
    localparam logic [3:0] OP_TERM   = 4'd15;

    // read address select
    localparam logic [2:0] RD_PC  = 3'd0;
    localparam logic [2:0] RD_B   = 3'd1;
    localparam logic [2:0] RD_C   = 3'd2;
    localparam logic [2:0] RD_A   = 3'd3;
    localparam logic [2:0] RD_PTR = 3'd4;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_FETCH = 10'b0000000010,
        S_RB    = 10'b0000000100,
        S_RC    = 10'b0000001000,
        S_RA    = 10'b0000010000,
        S_RP    = 10'b0000100000,
        S_WP    = 10'b0001000000,
        S_DGO   = 10'b0010000000,
        S_DWAIT = 10'b0100000000,
        S_WB    = 10'b1000000000
    } state_t;

    typedef struct packed {
        logic       capture;
        logic [2:0] rd_sel;
        logic       lat_cell;
        logic       lat_vb;
        logic       lat_vc;
        logic       lat_va;
        logic       lat_vp;
        logic       div_start;
        logic       commit;
    } ctl_t;

    typedef struct packed {
        logic exec_go;
        logic div_need;
        logic div_done;
        logic busy_out;
    } dp_stat_t;

endpackage

@@ design/tiny_memory_machine_core.sv @@
// Top level of the tiny memory machine core.
//
// Input channel (in_valid/in_ready) carries one command beat: load a cell,
// execute the instruction at the program counter, or restart at zero.
// Output channel (result_valid/result_ready) returns exactly one result
// beat per command: status, pc after the command, write output and the
// read-consumed flag.
// Load, restart and stopped executes go from fetch straight to write-back;
// a running execute first reads its operands, and a remainder also waits for the remainder unit.
// The cell memory has a single read port, so an instruction walks through
// cell fetch, reads of V(b), V(c), V(a) and the indirect pointer one after
// another; the remainder unit produces one quotient bit per cycle.
// One command is in flight at a time; in_ready stays low until the result
// beat has been taken, so a stalled receiver simply holds off new beats.
// The next beat can be taken in the cycle after the result beat is taken.
// Reset: pc and status go to zero and no result is pending; the cell store
// is then cleared one cell per cycle, holding in_ready low until it is done.
module tiny_memory_machine_core #(
    parameter int MEM_DEPTH = 256
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        cmd,
    input  logic [7:0]        cell_addr,
    input  logic [3:0]        opcode,
    input  logic [7:0]        operand_a,
    input  logic [7:0]        operand_b,
    input  logic [7:0]        operand_c,
    input  logic signed [7:0] in_value,
    output logic              result_valid,
    input  logic              result_ready,
    output logic [2:0]        status,
    output logic [8:0]        pc,
    output logic              out_valid,
    output logic signed [7:0] out_value,
    output logic              took_input
);

    tmm_pkg::ctl_t     ctl;
    tmm_pkg::dp_stat_t st;

    // sequencer: owns the state machine only
    tmm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .st       (st),
        .ctl      (ctl)
    );

    // datapath: memory, operand registers, execute and result registers
    tmm_datapath #(
        .MEM_DEPTH (MEM_DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .st           (st),
        .cmd          (cmd),
        .cell_addr    (cell_addr),
        .opcode       (opcode),
        .operand_a    (operand_a),
        .operand_b    (operand_b),
        .operand_c    (operand_c),
        .in_value     (in_value),
        .result_ready (result_ready),
        .result_valid (result_valid),
        .status       (status),
        .pc           (pc),
        .out_valid    (out_valid),
        .out_value    (out_value),
        .took_input   (took_input)
    );

    // a new beat never lands while a result is still pending
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |-> !result_valid)
        else $error("input accepted with result pending");

    // block is busy right after accepting a beat
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("ready high right after accept");

    // read and write instructions are exclusive
    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(out_valid && took_input))
        else $error("write and read flags both set");

    // ran-past-end always reports pc at the end of memory
    a_end_pc: assert property (@(posedge clk) disable iff (!rst_n)
        (status == tmm_pkg::ST_END) |-> (pc == 9'(MEM_DEPTH)))
        else $error("end status with wrong pc");

    a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
        pc <= 9'(MEM_DEPTH))
        else $error("pc out of range");

endmodule

@@ design/tmm_rem.sv @@
// Bit-serial signed remainder unit, truncating toward zero.
module tmm_rem (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic signed [7:0] dividend,
    input  logic signed [7:0] divisor,
    output logic              done,
    output logic signed [7:0] remainder
);

    logic [2:0] cnt_reg;
    logic       busy_reg;
    logic       done_reg;
    logic [7:0] rem_reg;
    logic [7:0] dvd_reg;
    logic [7:0] dvs_reg;
    logic       neg_reg;
    logic [8:0] trial;
    logic       fits;
    logic [7:0] rem_next;

    assign trial    = {rem_reg, dvd_reg[7]};
    assign fits     = trial >= {1'b0, dvs_reg};
    assign rem_next = fits ? 8'(trial - {1'b0, dvs_reg}) : trial[7:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 3'd1;
            if (cnt_reg == 3'd7)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dvd_reg <= dividend[7] ? 8'(-dividend) : dividend;
            dvs_reg <= divisor[7] ? 8'(-divisor) : divisor;
            neg_reg <= dividend[7];
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            dvd_reg <= {dvd_reg[6:0], 1'b0};
        end
    end

    assign done      = done_reg;
    assign remainder = neg_reg ? 8'(-rem_reg) : rem_reg;

endmodule

@@ design/tmm_ctrl.sv @@
// Sequencer for fetch, operand reads, remainder and write-back.
module tmm_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  tmm_pkg::dp_stat_t st,
    output tmm_pkg::ctl_t     ctl
);

    tmm_pkg::state_t state_reg;
    tmm_pkg::state_t state_next;

    assign in_ready = (state_reg == tmm_pkg::S_IDLE) && !st.busy_out;

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        ctl.rd_sel = tmm_pkg::RD_PC;
        unique case (state_reg)
            tmm_pkg::S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    ctl.capture = 1'b1;
                    state_next  = tmm_pkg::S_FETCH;
                end
            end
            tmm_pkg::S_FETCH:
            begin
                ctl.lat_cell = 1'b1;
                state_next   = st.exec_go ? tmm_pkg::S_RB : tmm_pkg::S_WB;
            end
            tmm_pkg::S_RB:
            begin
                ctl.rd_sel = tmm_pkg::RD_B;
                state_next = tmm_pkg::S_RC;
            end
            tmm_pkg::S_RC:
            begin
                ctl.rd_sel = tmm_pkg::RD_C;
                ctl.lat_vb = 1'b1;
                state_next = tmm_pkg::S_RA;
            end
            tmm_pkg::S_RA:
            begin
                ctl.rd_sel = tmm_pkg::RD_A;
                ctl.lat_vc = 1'b1;
                state_next = tmm_pkg::S_RP;
            end
            tmm_pkg::S_RP:
            begin
                ctl.rd_sel = tmm_pkg::RD_PTR;
                ctl.lat_va = 1'b1;
                state_next = tmm_pkg::S_WP;
            end
            tmm_pkg::S_WP:
            begin
                ctl.lat_vp = 1'b1;
                state_next = st.div_need ? tmm_pkg::S_DGO : tmm_pkg::S_WB;
            end
            tmm_pkg::S_DGO:
            begin
                ctl.div_start = 1'b1;
                state_next    = tmm_pkg::S_DWAIT;
            end
            tmm_pkg::S_DWAIT:
            begin
                if (st.div_done)
                begin
                    state_next = tmm_pkg::S_WB;
                end
            end
            tmm_pkg::S_WB:
            begin
                ctl.commit = 1'b1;
                state_next = tmm_pkg::S_IDLE;
            end
            default:
            begin
                state_next = tmm_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tmm_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ design/tmm_datapath.sv @@
// Cell store, operand registers, execute logic and result registers.
module tmm_datapath #(
    parameter int MEM_DEPTH = 256
) (
    input  logic              clk,
    input  logic              rst_n,
    input  tmm_pkg::ctl_t     ctl,
    output tmm_pkg::dp_stat_t st,
    input  logic [1:0]        cmd,
    input  logic [7:0]        cell_addr,
    input  logic [3:0]        opcode,
    input  logic [7:0]        operand_a,
    input  logic [7:0]        operand_b,
    input  logic [7:0]        operand_c,
    input  logic signed [7:0] in_value,
    input  logic              result_ready,
    output logic              result_valid,
    output logic [2:0]        status,
    output logic [8:0]        pc,
    output logic              out_valid,
    output logic signed [7:0] out_value,
    output logic              took_input
);

    // value byte and upper fields live apart so value writes touch one byte
    logic [7:0]  val_mem [MEM_DEPTH];
    logic [19:0] hi_mem  [MEM_DEPTH];

    // clearing pass after reset, one cell per cycle
    logic        clr_busy_reg;
    logic [7:0]  clr_addr_reg;

    logic [7:0]  rv_reg;
    logic [19:0] rh_reg;
    logic [7:0]  rval;
    logic [19:0] rhi;

    logic [1:0]  cmd_reg;
    logic [7:0]  inv_reg;
    logic [3:0]  op_reg;
    logic [7:0]  a_reg, b_reg, c_reg;
    logic [7:0]  vb_reg, vc_reg, va_reg, vp_reg;
    logic [8:0]  pc_reg;
    logic [2:0]  status_reg;
    logic        res_valid_reg;
    logic        outv_reg;
    logic [7:0]  oval_reg;
    logic        took_reg;

    logic [7:0]  rd_addr;
    logic        wr_en;
    logic [7:0]  wr_addr;
    logic [7:0]  wr_data;
    logic        ld_en;
    logic        val_we;
    logic [7:0]  val_waddr;
    logic [7:0]  val_wdata;
    logic        hi_we;
    logic [7:0]  hi_waddr;
    logic [19:0] hi_wdata;

    logic        vwr;
    logic [7:0]  vwr_addr;
    logic [7:0]  vwr_data;
    logic [8:0]  npc;
    logic [2:0]  nstat;
    logic        e_outv;
    logic [7:0]  e_oval;
    logic        e_took;
    logic [8:0]  pc_inc;
    logic [15:0] prod;
    logic        div_done;
    logic signed [7:0] rem_val;

    assign rval = rv_reg;
    assign rhi  = rh_reg;

    always_comb
    begin
        case (ctl.rd_sel)
            tmm_pkg::RD_B:   rd_addr = b_reg;
            tmm_pkg::RD_C:   rd_addr = c_reg;
            tmm_pkg::RD_A:   rd_addr = a_reg;
            tmm_pkg::RD_PTR: rd_addr = (op_reg == tmm_pkg::OP_STORE) ? rval : vb_reg;
            default:         rd_addr = pc_reg[7:0];
        endcase
    end

    assign st.exec_go  = (cmd_reg == tmm_pkg::CMD_EXEC) && (status_reg == tmm_pkg::ST_RUN)
                         && (pc_reg < 9'(MEM_DEPTH));
    assign st.div_need = st.exec_go && (op_reg == tmm_pkg::OP_MOD) && (vc_reg != 8'd0);
    assign st.div_done = div_done;
    assign st.busy_out = res_valid_reg || clr_busy_reg;

    tmm_rem u_rem (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (ctl.div_start),
        .dividend  (vb_reg),
        .divisor   (vc_reg),
        .done      (div_done),
        .remainder (rem_val)
    );

    assign pc_inc = pc_reg + 9'd1;
    assign prod   = 16'($signed(vb_reg) * $signed(vc_reg));

    always_comb
    begin
        vwr      = 1'b0;
        vwr_addr = a_reg;
        vwr_data = 8'd0;
        npc      = pc_inc;
        nstat    = tmm_pkg::ST_RUN;
        e_outv   = 1'b0;
        e_oval   = 8'd0;
        e_took   = 1'b0;
        unique case (op_reg)
            tmm_pkg::OP_READ:
            begin
                vwr      = 1'b1;
                vwr_data = inv_reg;
                e_took   = 1'b1;
            end
            tmm_pkg::OP_WRITE:
            begin
                e_outv = 1'b1;
                e_oval = va_reg;
            end
            tmm_pkg::OP_ASSIGN:
            begin
                vwr      = 1'b1;
                vwr_data = b_reg;
            end
            tmm_pkg::OP_MOVE:
            begin
                vwr      = 1'b1;
                vwr_data = vb_reg;
            end
            tmm_pkg::OP_LOAD:
            begin
                if (vb_reg[7])
                begin
                    nstat = tmm_pkg::ST_NEGADDR;
                    npc   = pc_reg;
                end
                else
                begin
                    vwr      = 1'b1;
                    vwr_data = vp_reg;
                end
            end
            tmm_pkg::OP_STORE:
            begin
                if (va_reg[7])
                begin
                    nstat = tmm_pkg::ST_NEGADDR;
                    npc   = pc_reg;
                end
                else
                begin
                    vwr      = 1'b1;
                    vwr_addr = va_reg;
                    vwr_data = vb_reg;
                end
            end
            tmm_pkg::OP_ADD:
            begin
                vwr      = 1'b1;
                vwr_data = vb_reg + vc_reg;
            end
            tmm_pkg::OP_SUB:
            begin
                vwr      = 1'b1;
                vwr_data = vb_reg - vc_reg;
            end
            tmm_pkg::OP_MUL:
            begin
                vwr      = 1'b1;
                vwr_data = prod[7:0];
            end
            tmm_pkg::OP_MOD:
            begin
                if (vc_reg == 8'd0)
                begin
                    nstat = tmm_pkg::ST_DIVZERO;
                    npc   = pc_reg;
                end
                else
                begin
                    vwr      = 1'b1;
                    vwr_data = rem_val;
                end
            end
            tmm_pkg::OP_EQ:
            begin
                vwr      = 1'b1;
                vwr_data = {7'd0, vb_reg == vc_reg};
            end
            tmm_pkg::OP_LESS:
            begin
                vwr      = 1'b1;
                vwr_data = {7'd0, $signed(vb_reg) < $signed(vc_reg)};
            end
            tmm_pkg::OP_JUMP:
            begin
                npc = {1'b0, a_reg};
            end
            tmm_pkg::OP_JUMPIF:
            begin
                if (vb_reg != 8'd0)
                begin
                    npc = {1'b0, a_reg};
                end
            end
            tmm_pkg::OP_TERM:
            begin
                nstat = tmm_pkg::ST_TERM;
                npc   = pc_reg;
            end
            default:
            begin
                vwr = 1'b0;
            end
        endcase
        if (nstat == tmm_pkg::ST_RUN && npc >= 9'(MEM_DEPTH))
        begin
            npc   = 9'(MEM_DEPTH);
            nstat = tmm_pkg::ST_END;
        end
    end

    assign ld_en   = ctl.capture && cmd == tmm_pkg::CMD_LOAD;
    assign wr_en   = ld_en || (ctl.commit && st.exec_go && vwr);
    assign wr_addr = ctl.capture ? cell_addr : vwr_addr;
    assign wr_data = ctl.capture ? operand_a : vwr_data;

    // clearing pass owns both write ports; no beat is taken meanwhile
    assign val_we    = clr_busy_reg || wr_en;
    assign val_waddr = clr_busy_reg ? clr_addr_reg : wr_addr;
    assign val_wdata = clr_busy_reg ? 8'd0 : wr_data;
    assign hi_we     = clr_busy_reg || ld_en;
    assign hi_waddr  = clr_busy_reg ? clr_addr_reg : cell_addr;
    assign hi_wdata  = clr_busy_reg ? 20'd0 : {opcode, operand_c, operand_b};

    always_ff @(posedge clk)
    begin
        if (val_we)
        begin
            val_mem[val_waddr] <= val_wdata;
        end
        if (hi_we)
        begin
            hi_mem[hi_waddr] <= hi_wdata;
        end
        rv_reg <= val_mem[rd_addr];
        rh_reg <= hi_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_busy_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 8'd1;
            if (clr_addr_reg == 8'(MEM_DEPTH - 1))
            begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            cmd_reg <= cmd;
            inv_reg <= in_value;
        end
        if (ctl.lat_cell)
        begin
            a_reg  <= rval;
            b_reg  <= rhi[7:0];
            c_reg  <= rhi[15:8];
            op_reg <= rhi[19:16];
        end
        if (ctl.lat_vb)
        begin
            vb_reg <= rval;
        end
        if (ctl.lat_vc)
        begin
            vc_reg <= rval;
        end
        if (ctl.lat_va)
        begin
            va_reg <= rval;
        end
        if (ctl.lat_vp)
        begin
            vp_reg <= rval;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= '0;
            status_reg    <= tmm_pkg::ST_RUN;
            res_valid_reg <= 1'b0;
            outv_reg      <= 1'b0;
            oval_reg      <= '0;
            took_reg      <= 1'b0;
        end
        else
        begin
            if (ctl.commit)
            begin
                res_valid_reg <= 1'b1;
                outv_reg      <= 1'b0;
                oval_reg      <= '0;
                took_reg      <= 1'b0;
                if (cmd_reg == tmm_pkg::CMD_RESTART)
                begin
                    pc_reg     <= '0;
                    status_reg <= tmm_pkg::ST_RUN;
                end
                else if (cmd_reg == tmm_pkg::CMD_EXEC && status_reg == tmm_pkg::ST_RUN)
                begin
                    if (st.exec_go)
                    begin
                        pc_reg     <= npc;
                        status_reg <= nstat;
                        outv_reg   <= e_outv;
                        oval_reg   <= e_oval;
                        took_reg   <= e_took;
                    end
                    else
                    begin
                        pc_reg     <= 9'(MEM_DEPTH);
                        status_reg <= tmm_pkg::ST_END;
                    end
                end
            end
            else if (res_valid_reg && result_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    assign result_valid = res_valid_reg;
    assign status       = status_reg;
    assign pc           = pc_reg;
    assign out_valid    = outv_reg;
    assign out_value    = oval_reg;
    assign took_input   = took_reg;

endmodule
